/* design/dtks_pkg.sv */
// Shared constants, codes and controller/datapath interface types for the
// device/topic key-share table. No dependencies.
package dtks_pkg;

  localparam int ROWS       = 16;
  localparam int ROW_BITS   = $clog2(ROWS);
  localparam int HASH_BITS  = 64;
  localparam int KEY_BITS   = 64;
  localparam int SHARE_BITS = 64;
  localparam int FIELD_BITS = 64;
  localparam int CMD_BITS   = 2;
  localparam int STAT_BITS  = 2;
  localparam int IDX_OUT_BITS = 4;

  localparam int IN_DATA_BITS  = 4 * FIELD_BITS;
  localparam int OUT_RAW_BITS  = IDX_OUT_BITS + 2 * FIELD_BITS;
  localparam int OUT_DATA_BITS = ((OUT_RAW_BITS + 7) / 8) * 8;

  localparam logic [ROW_BITS-1:0] LAST_ROW = ROW_BITS'(ROWS - 1);

  // command codes
  localparam logic [CMD_BITS-1:0] CMD_ADD_KEY   = 2'd0;
  localparam logic [CMD_BITS-1:0] CMD_ADD_SHARE = 2'd1;
  localparam logic [CMD_BITS-1:0] CMD_GET_SHARE = 2'd2;
  localparam logic [CMD_BITS-1:0] CMD_GET_KEY   = 2'd3;

  // result status codes
  localparam logic [STAT_BITS-1:0] ST_NEW  = 2'd0;
  localparam logic [STAT_BITS-1:0] ST_HIT  = 2'd1;
  localparam logic [STAT_BITS-1:0] ST_MISS = 2'd2;
  localparam logic [STAT_BITS-1:0] ST_FULL = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic scan_en;
    logic finish;
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;
    logic out_free;
  } sts_t;

endpackage

/* design/dtks_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dtks_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/dtks_ctrl.sv */
// Sequencer for the key-share table: accept, scan, finish.
// Depends on dtks_pkg for the control and status structs.
module dtks_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  dtks_pkg::sts_t sts,
  output dtks_pkg::ctl_t ctl
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    ctl.load    = 1'b0;
    ctl.scan_en = 1'b0;
    ctl.finish  = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.load   = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        ctl.scan_en = 1'b1;
        if (sts.scan_done) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        // hold until the result register can take the transaction
        if (sts.out_free) begin
          ctl.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* design/dtks_dp.sv */
// Datapath of the key-share table: row stores, used flags, scan pipeline,
// result register. Depends on dtks_pkg and dtks_ram.
module dtks_dp (
  input  logic                                   clk,
  input  logic                                   rst,
  input  dtks_pkg::ctl_t                         ctl,
  output dtks_pkg::sts_t                         sts,
  input  logic [dtks_pkg::CMD_BITS-1:0]          in_cmd,
  input  logic [dtks_pkg::IN_DATA_BITS-1:0]      in_data,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [dtks_pkg::STAT_BITS-1:0]         out_status,
  output logic [dtks_pkg::OUT_DATA_BITS-1:0]     out_data
);

  localparam int RB = dtks_pkg::ROW_BITS;
  localparam int HB = dtks_pkg::HASH_BITS;
  localparam int KB = dtks_pkg::KEY_BITS;
  localparam int SB = dtks_pkg::SHARE_BITS;
  localparam int FB = dtks_pkg::FIELD_BITS;

  // latched command
  logic [dtks_pkg::CMD_BITS-1:0] cmd_r;
  logic [HB-1:0] dev_r;
  logic [HB-1:0] top_r;
  logic [KB-1:0] key_r;
  logic [SB-1:0] shr_r;

  logic [dtks_pkg::ROWS-1:0] used;

  // scan pipeline
  logic [RB:0]   scan_addr;
  logic          ev_vld;
  logic [RB-1:0] ev_idx;

  logic          hit_found;
  logic [RB-1:0] hit_idx;
  logic [KB-1:0] last_key;
  logic          stopped;

  logic [dtks_pkg::STAT_BITS-1:0] res_status;
  logic [RB-1:0]                  res_row;
  logic [KB-1:0]                  res_key;
  logic [SB-1:0]                  res_share;

  logic [RB-1:0] out_row;
  logic [KB-1:0] out_key;
  logic [SB-1:0] out_share;

  // RAM ports
  logic [HB-1:0] dev_q, top_q;
  logic [KB-1:0] key_q;
  logic [SB-1:0] shr_q;
  logic          dev_we, top_we, key_we, shr_we;
  logic [HB-1:0] top_wd;
  logic [KB-1:0] key_wd;
  logic [SB-1:0] shr_wd;
  logic [RB-1:0] waddr;
  logic [RB-1:0] raddr;

  // evaluation
  logic          eval;
  logic          dev_match;
  logic          top_empty;
  logic          top_eq;
  logic          stop_c;
  logic          stop_now;
  logic          is_last;

  // free row search
  logic          free_any;
  logic [RB-1:0] free_idx;

  // finish
  logic                           claim;
  logic [dtks_pkg::STAT_BITS-1:0] fin_status;
  logic [RB-1:0]                  fin_row;
  logic [KB-1:0]                  fin_key;
  logic [SB-1:0]                  fin_share;

  assign raddr = scan_addr[RB-1:0];

  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = dtks_pkg::ROWS - 1; i >= 0; i--) begin
      if (!used[i]) begin
        free_any = 1'b1;
        free_idx = RB'(i);
      end
    end
  end

  assign eval      = ctl.scan_en && ev_vld;
  assign dev_match = used[ev_idx] && (dev_q == dev_r);
  assign top_empty = (top_q == '0);
  assign top_eq    = (top_q == top_r);
  assign is_last   = (ev_idx == dtks_pkg::LAST_ROW);

  always_comb begin
    case (cmd_r)
      dtks_pkg::CMD_ADD_KEY:   stop_c = 1'b0;
      dtks_pkg::CMD_ADD_SHARE: stop_c = dev_match && (top_empty || top_eq);
      dtks_pkg::CMD_GET_SHARE: stop_c = dev_match && top_eq;
      default:                 stop_c = dev_match;
    endcase
  end

  assign stop_now      = eval && stop_c;
  assign sts.scan_done = stop_now || (eval && is_last);
  assign sts.out_free  = !out_valid || out_ready;

  // final result: the stored hit when the scan stopped, else decided after the full scan
  always_comb begin
    claim      = 1'b0;
    fin_status = dtks_pkg::ST_MISS;
    fin_row    = '0;
    fin_key    = '0;
    fin_share  = '0;
    if (stopped) begin
      fin_status = res_status;
      fin_row    = res_row;
      fin_key    = res_key;
      fin_share  = res_share;
    end else begin
      case (cmd_r)
        dtks_pkg::CMD_ADD_KEY: begin
          if (hit_found) begin
            fin_status = dtks_pkg::ST_HIT;
            fin_row    = hit_idx;
          end else if (free_any) begin
            claim      = ctl.finish;
            fin_status = dtks_pkg::ST_NEW;
            fin_row    = free_idx;
          end else begin
            fin_status = dtks_pkg::ST_FULL;
          end
        end
        dtks_pkg::CMD_ADD_SHARE: begin
          if (!hit_found) begin
            fin_status = dtks_pkg::ST_MISS;
          end else if (free_any) begin
            claim      = ctl.finish;
            fin_status = dtks_pkg::ST_NEW;
            fin_row    = free_idx;
          end else begin
            fin_status = dtks_pkg::ST_FULL;
          end
        end
        default: begin
          fin_status = dtks_pkg::ST_MISS;
        end
      endcase
    end
  end

  // write ports: scan updates at the evaluated row, claims at the free row
  assign waddr  = claim ? free_idx : ev_idx;
  assign dev_we = claim;
  assign key_we = claim || (eval && (cmd_r == dtks_pkg::CMD_ADD_KEY) && dev_match);
  assign top_we = claim ||
                  (eval && (cmd_r == dtks_pkg::CMD_ADD_SHARE) && dev_match && top_empty);
  assign shr_we = claim || (eval && (cmd_r == dtks_pkg::CMD_ADD_SHARE) && stop_c);
  assign key_wd = (cmd_r == dtks_pkg::CMD_ADD_SHARE) ? last_key : key_r;
  assign top_wd = (cmd_r == dtks_pkg::CMD_ADD_KEY) ? '0 : top_r;
  assign shr_wd = (cmd_r == dtks_pkg::CMD_ADD_KEY) ? '0 : shr_r;

  dtks_ram #(.WIDTH(HB), .DEPTH(dtks_pkg::ROWS)) u_dev_ram (
    .clk(clk), .we(dev_we), .waddr(waddr), .wdata(dev_r), .raddr(raddr), .rdata(dev_q)
  );
  dtks_ram #(.WIDTH(HB), .DEPTH(dtks_pkg::ROWS)) u_top_ram (
    .clk(clk), .we(top_we), .waddr(waddr), .wdata(top_wd), .raddr(raddr), .rdata(top_q)
  );
  dtks_ram #(.WIDTH(KB), .DEPTH(dtks_pkg::ROWS)) u_key_ram (
    .clk(clk), .we(key_we), .waddr(waddr), .wdata(key_wd), .raddr(raddr), .rdata(key_q)
  );
  dtks_ram #(.WIDTH(SB), .DEPTH(dtks_pkg::ROWS)) u_shr_ram (
    .clk(clk), .we(shr_we), .waddr(waddr), .wdata(shr_wd), .raddr(raddr), .rdata(shr_q)
  );

  // payload registers
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r <= in_cmd;
      dev_r <= in_data[HB-1:0];
      top_r <= in_data[FB +: HB];
      key_r <= in_data[2*FB +: KB];
      shr_r <= in_data[3*FB +: SB];
    end
    if (ctl.scan_en && (scan_addr < (RB+1)'(dtks_pkg::ROWS))) begin
      ev_idx <= scan_addr[RB-1:0];
    end
    if (eval && dev_match) begin
      last_key <= key_q;
      if (!hit_found) begin
        hit_idx <= ev_idx;
      end
    end
    if (stop_now) begin
      res_status <= dtks_pkg::ST_HIT;
      res_row    <= ev_idx;
      res_key    <= (cmd_r == dtks_pkg::CMD_GET_KEY) ? key_q : '0;
      res_share  <= (cmd_r == dtks_pkg::CMD_GET_SHARE) ? shr_q : '0;
    end
    if (ctl.finish) begin
      out_status <= fin_status;
      out_row    <= fin_row;
      out_key    <= fin_key;
      out_share  <= fin_share;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      used      <= '0;
      scan_addr <= '0;
      ev_vld    <= 1'b0;
      hit_found <= 1'b0;
      stopped   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ctl.load) begin
        scan_addr <= '0;
        ev_vld    <= 1'b0;
        hit_found <= 1'b0;
        stopped   <= 1'b0;
      end else if (ctl.scan_en) begin
        // advance the read address; drop the pipeline after the last row
        if (scan_addr < (RB+1)'(dtks_pkg::ROWS)) begin
          scan_addr <= scan_addr + 1'b1;
          ev_vld    <= 1'b1;
        end else begin
          ev_vld <= 1'b0;
        end
      end
      if (eval && dev_match) begin
        hit_found <= 1'b1;
      end
      if (stop_now) begin
        stopped <= 1'b1;
      end
      if (claim) begin
        used[free_idx] <= 1'b1;
      end
      if (ctl.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign out_data = {{(dtks_pkg::OUT_DATA_BITS - dtks_pkg::OUT_RAW_BITS){1'b0}},
                     FB'(out_share), FB'(out_key), dtks_pkg::IDX_OUT_BITS'(out_row)};

endmodule

/* design/device_topic_key_share_table.sv */
// Device/topic key-share table: a 16-row store of device hash, topic hash,
// master key and secret share, driven by add_key, add_share, get_share and
// get_key commands on s_tuser, one result transaction per command on the
// m side. A command is accepted, then scans the rows one per cycle
// through the registered read port of the row RAMs, ending early when a
// get or an add_share hits, then finishes once the output register is free.
// The result sits in an output register, so the next command is taken while
// the previous result waits for m_tready. Depends on dtks_pkg, dtks_ctrl,
// dtks_dp and dtks_ram.
module device_topic_key_share_table (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // device_hash[63:0], topic_hash[127:64], key_in[191:128], share_in[255:192]
  input  logic [dtks_pkg::IN_DATA_BITS-1:0]   s_tdata,
  // command[1:0]
  input  logic [dtks_pkg::CMD_BITS-1:0]       s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // row_index[3:0], key_out[67:4], share_out[131:68], zero pad up to 135
  output logic [dtks_pkg::OUT_DATA_BITS-1:0]  m_tdata,
  // status[1:0]
  output logic [dtks_pkg::STAT_BITS-1:0]      m_tuser
);

  dtks_pkg::ctl_t ctl;
  dtks_pkg::sts_t sts;

  dtks_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .ctl      (ctl)
  );

  dtks_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .sts        (sts),
    .in_cmd     (s_tuser),
    .in_data    (s_tdata),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_status (m_tuser),
    .out_data   (m_tdata)
  );

endmodule

/* test/tb_device_topic_key_share_table.sv */
// Self-checking bench for device_topic_key_share_table: directed and random
// table commands with random stalls on both stream sides, checked against a
// cycle-free model of the row table. Depends on dtks_pkg and the design files.
`timescale 1ns / 1ps

module tb_device_topic_key_share_table;

  localparam int RANDOM_CMDS = 700;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DEV_POOL    = 10;
  localparam int TOPIC_POOL  = 5;

  typedef struct packed {
    logic [dtks_pkg::STAT_BITS-1:0]    status;
    logic [dtks_pkg::IDX_OUT_BITS-1:0] row;
    logic [dtks_pkg::KEY_BITS-1:0]     key;
    logic [dtks_pkg::SHARE_BITS-1:0]   share;
  } table_result_t;

  class key_table_scoreboard;
    bit                              used[dtks_pkg::ROWS];
    logic [dtks_pkg::HASH_BITS-1:0]  dev_tab[dtks_pkg::ROWS];
    logic [dtks_pkg::HASH_BITS-1:0]  topic_tab[dtks_pkg::ROWS];
    logic [dtks_pkg::KEY_BITS-1:0]   key_tab[dtks_pkg::ROWS];
    logic [dtks_pkg::SHARE_BITS-1:0] share_tab[dtks_pkg::ROWS];
    table_result_t                   pending_results[$];
    int                              errors;
    int                              commands;
    int                              status_seen[4];

    function void clear_table();
      for (int i = 0; i < dtks_pkg::ROWS; i++) begin
        used[i]      = 1'b0;
        dev_tab[i]   = '0;
        topic_tab[i] = '0;
        key_tab[i]   = '0;
        share_tab[i] = '0;
      end
    endfunction

    function int free_row();
      for (int i = 0; i < dtks_pkg::ROWS; i++)
        if (!used[i]) return i;
      return -1;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    // Predict the result of one accepted command and update the table copy.
    function void note_command(logic [dtks_pkg::CMD_BITS-1:0] cmd,
                               logic [dtks_pkg::HASH_BITS-1:0] dev,
                               logic [dtks_pkg::HASH_BITS-1:0] top,
                               logic [dtks_pkg::KEY_BITS-1:0] key,
                               logic [dtks_pkg::SHARE_BITS-1:0] shr);
      table_result_t r;
      int hit;
      int slot;
      bit done;
      r    = '0;
      hit  = -1;
      done = 1'b0;
      case (cmd)
        dtks_pkg::CMD_ADD_KEY: begin
          for (int i = 0; i < dtks_pkg::ROWS; i++) begin
            if (used[i] && dev_tab[i] == dev) begin
              key_tab[i] = key;
              if (hit < 0) hit = i;
            end
          end
          if (hit >= 0) begin
            r.status = dtks_pkg::ST_HIT;
            r.row    = dtks_pkg::IDX_OUT_BITS'(hit);
          end else begin
            slot = free_row();
            if (slot < 0) begin
              r.status = dtks_pkg::ST_FULL;
            end else begin
              used[slot]      = 1'b1;
              dev_tab[slot]   = dev;
              key_tab[slot]   = key;
              topic_tab[slot] = '0;
              share_tab[slot] = '0;
              r.status = dtks_pkg::ST_NEW;
              r.row    = dtks_pkg::IDX_OUT_BITS'(slot);
            end
          end
        end
        dtks_pkg::CMD_ADD_SHARE: begin
          for (int i = 0; i < dtks_pkg::ROWS && !done; i++) begin
            if (used[i] && dev_tab[i] == dev) begin
              hit = i;
              // an empty topic slot takes the new topic, a matching one is updated
              if (topic_tab[i] == '0 || topic_tab[i] == top) begin
                topic_tab[i] = top;
                share_tab[i] = shr;
                r.status = dtks_pkg::ST_HIT;
                r.row    = dtks_pkg::IDX_OUT_BITS'(i);
                done     = 1'b1;
              end
            end
          end
          if (!done) begin
            if (hit < 0) begin
              r.status = dtks_pkg::ST_MISS;
            end else begin
              slot = free_row();
              if (slot < 0) begin
                r.status = dtks_pkg::ST_FULL;
              end else begin
                // new topic row inherits the key of the last row of that device
                used[slot]      = 1'b1;
                dev_tab[slot]   = dev;
                key_tab[slot]   = key_tab[hit];
                topic_tab[slot] = top;
                share_tab[slot] = shr;
                r.status = dtks_pkg::ST_NEW;
                r.row    = dtks_pkg::IDX_OUT_BITS'(slot);
              end
            end
          end
        end
        dtks_pkg::CMD_GET_SHARE: begin
          r.status = dtks_pkg::ST_MISS;
          for (int i = 0; i < dtks_pkg::ROWS && !done; i++) begin
            if (used[i] && dev_tab[i] == dev && topic_tab[i] == top) begin
              r.status = dtks_pkg::ST_HIT;
              r.row    = dtks_pkg::IDX_OUT_BITS'(i);
              r.share  = share_tab[i];
              done     = 1'b1;
            end
          end
        end
        default: begin
          r.status = dtks_pkg::ST_MISS;
          for (int i = 0; i < dtks_pkg::ROWS && !done; i++) begin
            if (used[i] && dev_tab[i] == dev) begin
              r.status = dtks_pkg::ST_HIT;
              r.row    = dtks_pkg::IDX_OUT_BITS'(i);
              r.key    = key_tab[i];
              done     = 1'b1;
            end
          end
        end
      endcase
      commands++;
      status_seen[r.status]++;
      pending_results.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task check_result(logic [dtks_pkg::STAT_BITS-1:0] status,
                      logic [dtks_pkg::IDX_OUT_BITS-1:0] row,
                      logic [dtks_pkg::KEY_BITS-1:0] key,
                      logic [dtks_pkg::SHARE_BITS-1:0] share);
      table_result_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected result status %0d row %0d", status, row));
        return;
      end
      want = pending_results.pop_front();
      if (status !== want.status)
        report($sformatf("status %0d, want %0d", status, want.status));
      if (row !== want.row)
        report($sformatf("row_index %0d, want %0d", row, want.row));
      if (key !== want.key)
        report($sformatf("key_out %h, want %h", key, want.key));
      if (share !== want.share)
        report($sformatf("share_out %h, want %h", share, want.share));
    endtask
  endclass

  logic                               clk;
  logic                               rst;
  logic                               s_tvalid;
  logic                               s_tready;
  logic [dtks_pkg::IN_DATA_BITS-1:0]  s_tdata;
  logic [dtks_pkg::CMD_BITS-1:0]      s_tuser;
  logic                               m_tvalid;
  logic                               m_tready;
  logic [dtks_pkg::OUT_DATA_BITS-1:0] m_tdata;
  logic [dtks_pkg::STAT_BITS-1:0]     m_tuser;

  key_table_scoreboard            sb;
  bit                             quiet;
  int                             cycles;
  logic [dtks_pkg::HASH_BITS-1:0] dev_pool[DEV_POOL];
  logic [dtks_pkg::HASH_BITS-1:0] topic_pool[TOPIC_POOL];

  device_topic_key_share_table dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Mostly short gaps, a few long ones; none while quiet.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_command(logic [dtks_pkg::CMD_BITS-1:0] cmd,
                              logic [dtks_pkg::HASH_BITS-1:0] dev,
                              logic [dtks_pkg::HASH_BITS-1:0] top,
                              logic [dtks_pkg::KEY_BITS-1:0] key,
                              logic [dtks_pkg::SHARE_BITS-1:0] shr);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {shr, key, top, dev};
    s_tuser  <= cmd;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic send_random_command();
    logic [dtks_pkg::CMD_BITS-1:0]  cmd;
    logic [dtks_pkg::HASH_BITS-1:0] dev;
    logic [dtks_pkg::HASH_BITS-1:0] top;
    int r;
    r = $urandom_range(0, 99);
    if (r < 20)      cmd = dtks_pkg::CMD_ADD_KEY;
    else if (r < 45) cmd = dtks_pkg::CMD_ADD_SHARE;
    else if (r < 75) cmd = dtks_pkg::CMD_GET_SHARE;
    else             cmd = dtks_pkg::CMD_GET_KEY;
    // stay mostly inside small pools so rows get hit, with some stray hashes
    dev = ($urandom_range(0, 9) == 0) ? rand64() : dev_pool[$urandom_range(0, DEV_POOL-1)];
    top = ($urandom_range(0, 9) == 0) ? rand64()
                                      : topic_pool[$urandom_range(0, TOPIC_POOL-1)];
    send_command(cmd, dev, top, rand64(), rand64());
  endtask

  // Receiver: stall in random bursts.
  initial begin
    int n;
    @(posedge clk);
    forever begin
      n = pick_gap();
      if (n > 0) begin
        m_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready)
      sb.note_command(s_tuser, s_tdata[63:0], s_tdata[127:64], s_tdata[191:128],
                      s_tdata[255:192]);
    if (!rst && m_tvalid && m_tready)
      sb.check_result(m_tuser, m_tdata[3:0], m_tdata[67:4], m_tdata[131:68]);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    logic [dtks_pkg::HASH_BITS-1:0] dev_a;
    logic [dtks_pkg::HASH_BITS-1:0] dev_b;
    logic [dtks_pkg::HASH_BITS-1:0] topic_t2;
    logic [dtks_pkg::HASH_BITS-1:0] ones;
    sb = new();
    sb.clear_table();
    quiet    = 1'b0;
    cycles   = 0;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = dtks_pkg::CMD_ADD_KEY;
    m_tready = 1'b0;
    ones     = '1;
    dev_a    = rand64();
    dev_b    = ones;
    topic_t2 = rand64();
    dev_pool[0]   = '0;
    dev_pool[1]   = ones;
    topic_pool[0] = '0;
    topic_pool[1] = ones;
    for (int i = 2; i < DEV_POOL; i++) dev_pool[i] = rand64();
    for (int i = 2; i < TOPIC_POOL; i++) topic_pool[i] = rand64();

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: misses on the empty table (the model's unused rows hold device zero),
    // new rows, key updates over several rows, topic fill, update and
    // new-topic rows, and topic zero in add_share.
    send_command(dtks_pkg::CMD_GET_KEY,   '0,    '0,       rand64(), rand64());
    send_command(dtks_pkg::CMD_GET_SHARE, '0,    '0,       rand64(), rand64());
    send_command(dtks_pkg::CMD_ADD_SHARE, dev_a, ones,     rand64(), rand64());
    send_command(dtks_pkg::CMD_ADD_KEY,   '0,    rand64(), ones,     rand64());
    send_command(dtks_pkg::CMD_GET_KEY,   '0,    rand64(), rand64(), rand64());
    send_command(dtks_pkg::CMD_GET_SHARE, '0,    '0,       rand64(), rand64());
    send_command(dtks_pkg::CMD_ADD_KEY,   dev_a, rand64(), rand64(), rand64());
    send_command(dtks_pkg::CMD_ADD_SHARE, dev_a, ones,     rand64(), ones);
    send_command(dtks_pkg::CMD_ADD_SHARE, dev_a, ones,     rand64(), rand64());
    send_command(dtks_pkg::CMD_ADD_SHARE, dev_a, topic_t2, rand64(), rand64());
    send_command(dtks_pkg::CMD_ADD_KEY,   dev_a, rand64(), '0,       rand64());
    send_command(dtks_pkg::CMD_GET_KEY,   dev_a, rand64(), rand64(), rand64());
    send_command(dtks_pkg::CMD_GET_SHARE, dev_a, topic_t2, rand64(), rand64());
    send_command(dtks_pkg::CMD_ADD_SHARE, dev_a, '0,       rand64(), rand64());
    send_command(dtks_pkg::CMD_ADD_SHARE, dev_a, '0,       rand64(), ones);
    send_command(dtks_pkg::CMD_GET_SHARE, dev_a, '0,       rand64(), rand64());
    send_command(dtks_pkg::CMD_ADD_KEY,   dev_b, rand64(), rand64(), rand64());
    send_command(dtks_pkg::CMD_GET_SHARE, dev_b, ones,     rand64(), rand64());
    send_command(dtks_pkg::CMD_GET_KEY,   rand64(), rand64(), rand64(), rand64());
    send_command(dtks_pkg::CMD_ADD_SHARE, '0,    topic_t2, rand64(), '0);
    send_command(dtks_pkg::CMD_GET_SHARE, '0,    topic_t2, rand64(), rand64());

    // Random: each block picks at random between stalling and back-to-back traffic.
    for (int blk = 0; blk < RANDOM_CMDS / 50; blk++) begin
      quiet = ($urandom_range(0, 3) == 0);
      repeat (50) send_random_command();
    end
    s_tvalid <= 1'b0;
    quiet = 1'b0;

    // let the monitor log the last transaction before draining
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (25) @(posedge clk);

    $display("Ran %0d commands in %0d cycles; mismatches %0d", sb.commands, cycles,
             sb.errors);
    $display("Results by status: new %0d, hit %0d, miss %0d, full %0d",
             sb.status_seen[dtks_pkg::ST_NEW], sb.status_seen[dtks_pkg::ST_HIT],
             sb.status_seen[dtks_pkg::ST_MISS], sb.status_seen[dtks_pkg::ST_FULL]);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
